### rtl/core/compacting_id_set_assert.svh
// assertion macros shared by the set logic
`ifndef COMPACTING_ID_SET_ASSERT_SVH
`define COMPACTING_ID_SET_ASSERT_SVH

// property checked on every clock edge outside reset
`define CIS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("set check failed");

// condition that must never be seen outside reset
`define CIS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden set condition");

`endif

### rtl/core/cis_pkg.sv
`default_nettype none

package cis_pkg;

  // capacity and id width of the set
  localparam int unsigned SLOTS    = 16;
  localparam int unsigned ID_WIDTH = 32;

  // fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ITEM_W  = 32;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COUNT_W = 5;

  // derived widths
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_READ = 2'd2
  } cis_cmd_e;

  // contents of one slot
  typedef struct packed {
    logic                valid;
    logic [ID_WIDTH-1:0] id;
  } cis_slot_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                add;
    logic                del;
    logic [ID_WIDTH-1:0] key;
  } cis_ctl_t;

  // one result
  typedef struct packed {
    logic               status;
    logic [COUNT_W-1:0] count;
    logic [ITEM_W-1:0]  read_id;
    logic               read_valid;
  } cis_rsp_t;

endpackage

`default_nettype wire

### rtl/core/cis_req_if.sv
`default_nettype none

interface cis_req_if import cis_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ITEM_W-1:0] item_id;
  logic [IDX_W-1:0]  slot_index;

  modport source (output valid, output cmd, output item_id, output slot_index, input ready);
  modport sink (input valid, input cmd, input item_id, input slot_index, output ready);
endinterface

`default_nettype wire

### rtl/core/cis_rsp_if.sv
`default_nettype none

interface cis_rsp_if import cis_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [COUNT_W-1:0] count;
  logic [ITEM_W-1:0]  read_id;
  logic               read_valid;

  modport source (output valid, output status, output count, output read_id,
                  output read_valid, input ready);
  modport sink (input valid, input status, input count, input read_id,
                input read_valid, output ready);
endinterface

`default_nettype wire

### rtl/core/cis_cell.sv
`default_nettype none

module cis_cell import cis_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cis_ctl_t  ctl_i,
  input  wire logic      prev_valid_i,
  input  wire cis_slot_t right_i,
  input  wire logic      shift_i,
  output cis_slot_t      slot_o,
  output logic           shift_o,
  output logic           match_o
);

  logic                valid_q, valid_d;
  logic [ID_WIDTH-1:0] id_q, id_d;

  assign match_o = valid_q && (id_q == ctl_i.key);
  // a match here or in any lower slot pulls this slot from its right neighbor
  assign shift_o = shift_i | match_o;

  always_comb begin
    priority if (ctl_i.del && shift_o) begin
      valid_d = right_i.valid;
      id_d    = right_i.id;
    end else if (ctl_i.add && !valid_q && prev_valid_i) begin
      // first empty slot
      valid_d = 1'b1;
      id_d    = ctl_i.key;
    end else begin
      valid_d = valid_q;
      id_d    = id_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign slot_o.valid = valid_q;
  assign slot_o.id    = id_q;

endmodule

`default_nettype wire

### rtl/core/compacting_id_set.sv
// the result of an accepted item is held in the output register
// throughput: one item per cycle while results are taken; every slot cell compares and shifts in the same cycle
// the output register frees as the result is taken, so items flow back to back
// reset: asynchronous, active low; empties the set, clears the count, no result pending
// no clearing pass: slot valid bits clear at once
`default_nettype none
`include "compacting_id_set_assert.svh"

module compacting_id_set import cis_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cis_req_if.sink   req_i,
  cis_rsp_if.source rsp_o
);

  // chain wiring: entry SLOTS is the always-empty slot past the end
  cis_slot_t          slot  [SLOTS+1];
  logic [SLOTS:0]     shift;
  logic [SLOTS-1:0]   match_vec;
  logic [SLOTS-1:0]   valid_vec;
  logic [SLOTS-1:0]   prev_valid;

  cis_ctl_t           ctl;
  logic               acc;
  logic               hit;
  logic               full;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  cis_rsp_t           rsp_q, rsp_d;
  logic               rsp_valid_q;
  logic               rd_in_range;
  cis_slot_t          rd_slot;

  // handshake: accept whenever the output register is free or being emptied
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  assign full = (cnt_q == CNT_W'(SLOTS));
  // any match anywhere shows up at the end of the shift chain
  assign hit  = shift[SLOTS];

  // command broadcast to all cells
  assign ctl.key = ID_WIDTH'(req_i.item_id);
  assign ctl.add = acc && (req_i.cmd == CMD_ADD) && !full && !hit;
  assign ctl.del = acc && (req_i.cmd == CMD_DEL);

  assign shift[0]         = 1'b0;
  assign slot[SLOTS].valid = 1'b0;
  assign slot[SLOTS].id    = '0;

  // row of slot cells, each linked to its neighbors
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_valid[i] = 1'b1;
    end else begin : g_rest
      assign prev_valid[i] = slot[i-1].valid;
    end

    cis_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_valid[i]),
      .right_i      (slot[i+1]),
      .shift_i      (shift[i]),
      .slot_o       (slot[i]),
      .shift_o      (shift[i+1]),
      .match_o      (match_vec[i])
    );

    assign valid_vec[i] = slot[i].valid;
  end

  // read port: one slot picked by the index
  assign rd_in_range = ({1'b0, req_i.slot_index} < (IDX_W + 1)'(SLOTS));
  assign rd_slot     = slot[{1'b0, req_i.slot_index[SLOT_W-1:0]}];

  // count after the operation
  always_comb begin
    priority if (ctl.add) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctl.del && hit) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  // result fields
  always_comb begin
    rsp_d.count      = COUNT_W'(cnt_d);
    rsp_d.status     = 1'b1;
    rsp_d.read_id    = '0;
    rsp_d.read_valid = 1'b0;
    unique case (req_i.cmd)
      CMD_ADD: begin
        rsp_d.status = full;
      end
      CMD_DEL: begin
        rsp_d.status = !hit;
      end
      CMD_READ: begin
        rsp_d.status = !rd_in_range;
        if (rd_in_range && rd_slot.valid) begin
          rsp_d.read_id    = ITEM_W'(rd_slot.id);
          rsp_d.read_valid = 1'b1;
        end
      end
      default: begin
        // unused command code: error, no change
        rsp_d.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (acc) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_q.status;
  assign rsp_o.count      = rsp_q.count;
  assign rsp_o.read_id    = rsp_q.read_id;
  assign rsp_o.read_valid = rsp_q.read_valid;

  // count tracks the number of occupied slots
  `CIS_ASSERT(a_count_matches, int'(cnt_q) == $countones(valid_vec))
  // occupied slots stay packed from slot 0
  `CIS_ASSERT(a_packed, $onehot({1'b0, valid_vec} + (SLOTS + 1)'(1)))
  // the key is never held in more than one slot
  `CIS_ASSERT(a_unique, $onehot0(match_vec))
  // a delete that misses leaves the set alone
  `CIS_ASSERT(a_del_miss_stable, (ctl.del && !hit) |=> $stable(valid_vec))

endmodule

`default_nettype wire
